// File: rtl/qwo_pkg.sv
`timescale 1ns / 1ps
// Quadrature wheel odometry package: fixed-point constants, quarter-wave sine
// ROM built at elaboration, and rounding / saturation helpers. No dependencies.
package qwo_pkg;

  localparam int SINE_DEPTH = 256;
  localparam int SINE_AW    = 8;

  localparam logic [31:0] TWO_OVER_PI_Q32 = 32'd2734261103;
  localparam logic [63:0] HALF_PI_Q30     = 64'd1686629713;
  localparam logic [31:0] RECIP_60        = 32'd71582788;
  localparam logic [31:0] RECIP_157       = 32'd27356479;

  localparam logic signed [23:0] VEL_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] VEL_MIN = -24'sh800000;

  typedef logic [15:0] sine_rom_t [SINE_DEPTH];

  function automatic sine_rom_t build_sine();
    sine_rom_t   rom;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] val;
    for (int k = 0; k < SINE_DEPTH; k++) begin
      x    = (HALF_PI_Q30 * 64'(k)) >> SINE_AW;
      x2   = (x * x) >> 30;
      term = x;
      sum  = x;
      for (int n = 1; n <= 8; n++) begin
        term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
        if ((n % 2) == 1) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
      val    = (sum * 64'd65536 + 64'd536870912) >> 30;
      rom[k] = (val > 64'd65535) ? 16'hFFFF : val[15:0];
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine();

  // Sine of a 10-bit phase (four quarters of SINE_DEPTH steps).
  function automatic logic signed [17:0] sine_at(input logic [9:0] idx);
    logic [7:0]         off;
    logic [16:0]        fwd;
    logic [16:0]        rev;
    logic signed [17:0] res;
    off = idx[7:0];
    fwd = {1'b0, SINE_ROM[off]};
    rev = (off == 8'd0) ? 17'd65536 : {1'b0, SINE_ROM[8'(~off + 8'd1)]};
    case (idx[9:8])
      2'd0:    res = $signed({1'b0, fwd});
      2'd1:    res = $signed({1'b0, rev});
      2'd2:    res = -$signed({1'b0, fwd});
      default: res = -$signed({1'b0, rev});
    endcase
    return res;
  endfunction

  // Shift right with rounding half away from zero.
  function automatic logic signed [65:0] rshift8(input logic signed [65:0] v);
    return (v + 66'sd128 - $signed({65'd0, v[65]})) >>> 8;
  endfunction

  function automatic logic signed [65:0] rshift16(input logic signed [65:0] v);
    return (v + 66'sd32768 - $signed({65'd0, v[65]})) >>> 16;
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [65:0] v);
    if (v > 66'(VEL_MAX)) return VEL_MAX;
    if (v < 66'(VEL_MIN)) return VEL_MIN;
    return v[23:0];
  endfunction

  // Velocity code numerator: clamp (v + 30 m/s) and scale by 65535 / 65536.
  function automatic logic [21:0] vel_num(input logic signed [23:0] v);
    logic signed [24:0] n;
    logic [21:0]        nc;
    logic [37:0]        w;
    n = 25'(v) + 25'sd1966080;
    if (n <= 0) nc = 22'd0;
    else if (n >= 25'sd3932160) nc = 22'd3932160;
    else nc = n[21:0];
    w = ({nc, 16'd0} - 38'(nc));
    return w[37:16];
  endfunction

endpackage

// File: rtl/qwo_mul.sv
`timescale 1ns / 1ps
// Shared signed 33x33 multiplier with a registered product.
// Standalone; used by the odometry sequencer.
module qwo_mul (
  input  logic               clk,
  input  logic signed [32:0] op_a,
  input  logic signed [32:0] op_b,
  output logic signed [65:0] prod_r
);

  logic signed [65:0] prod_nxt;

  assign prod_nxt = 66'(op_a) * 66'(op_b);

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule

// File: rtl/quadrature_wheel_odometry_top.sv
`timescale 1ns / 1ps
// Quadrature wheel odometry top level: decoder, tick sequencer, output register.
// Pin sample: result registered in the accept cycle, 1 beat/cycle unless stalled or busy.
// Sample tick: ST_W1 to ST_J in turn, result loaded in ST_J; next beat taken in idle.
// Reset (rst_n low, synchronous) clears decoder, positions; gains and period to defaults.
// Depends on qwo_pkg and qwo_mul.
module quadrature_wheel_odometry_top #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  // configuration write port
  input  logic          cfg_wr_en,
  input  logic [1:0]    cfg_index,
  input  logic [23:0]   cfg_data,
  // input stream
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [39:0]   in_tdata,   // pin_a, pin_b, timer_count[15:0], heading[15:0], pad
  input  logic          in_tuser,   // func: 0 pin sample, 1 sample tick
  // result stream
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [143:0]  out_tdata,  // decoder_count, vx_code, vy_code, heading_code,
                                    // x_position, y_position
  output logic          out_tuser   // frame_valid
);

  localparam logic [1:0] REG_XGAIN = 2'd0;
  localparam logic [1:0] REG_YGAIN = 2'd1;
  localparam logic [1:0] REG_TPER  = 2'd2;

  // sequencer states; ST_W1..ST_H each issue a product, ST_W2..ST_I consume the previous
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_W1   = 4'd1;
  localparam logic [3:0] ST_W2   = 4'd2;
  localparam logic [3:0] ST_STP  = 4'd3;
  localparam logic [3:0] ST_LUT  = 4'd4;
  localparam logic [3:0] ST_A    = 4'd5;
  localparam logic [3:0] ST_B    = 4'd6;
  localparam logic [3:0] ST_C    = 4'd7;
  localparam logic [3:0] ST_D    = 4'd8;
  localparam logic [3:0] ST_E    = 4'd9;
  localparam logic [3:0] ST_F    = 4'd10;
  localparam logic [3:0] ST_G    = 4'd11;
  localparam logic [3:0] ST_H    = 4'd12;
  localparam logic [3:0] ST_I    = 4'd13;
  localparam logic [3:0] ST_J    = 4'd14;

  // unpack input beat
  logic               in_a, in_b;
  logic [15:0]        in_timer;
  logic signed [15:0] in_head;
  assign in_a     = in_tdata[0];
  assign in_b     = in_tdata[1];
  assign in_timer = in_tdata[17:2];
  assign in_head  = $signed(in_tdata[33:18]);

  // configuration
  logic [23:0] xgain_r, ygain_r;
  logic [15:0] tper_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xgain_r <= 24'd219894;
      ygain_r <= 24'd219894;
      tper_r  <= 16'd655;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_XGAIN: xgain_r <= cfg_data;
        REG_YGAIN: ygain_r <= cfg_data;
        REG_TPER:  tper_r  <= cfg_data[15:0];
        default:   ;
      endcase
    end
  end

  // control and odometry state
  logic [3:0]             state_r, state_nxt;
  logic                   la_r, lb_r;
  logic [COUNT_WIDTH-1:0] quad_r, quad_nxt;
  logic [COUNT_WIDTH-1:0] cnt_tick_r;
  logic [15:0]            tmr_tick_r;
  logic [31:0]            posx_r, posy_r;
  logic                   out_valid_r;

  // tick datapath registers
  logic signed [32:0] dq_r;
  logic signed [16:0] dt_r;
  logic [16:0]        mag_r;
  logic               hneg_r;
  logic [23:0]        mh_r;
  logic [15:0]        hcode_r;
  logic signed [23:0] w1_r, w2_r, vx_r, vy_r;
  logic signed [17:0] sin_r, cos_r;
  logic signed [65:0] acc_r;
  logic [15:0]        qh_r, qx_r, qy_r;

  // output payload registers
  logic [31:0] o_count_r, o_px_r, o_py_r;
  logic [15:0] o_vx_r, o_vy_r, o_hd_r;
  logic        o_frame_r;

  logic slot_free, accept, pin_acc, tick_acc, tick_done;

  assign slot_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE) && slot_free;
  assign accept    = in_tvalid && in_tready;
  assign pin_acc   = accept && !in_tuser;
  assign tick_acc  = accept && in_tuser;
  assign tick_done = (state_r == ST_J) && slot_free;

  // quadrature decode: A change then B change, both against the new levels
  always_comb begin
    quad_nxt = quad_r;
    if (in_a != la_r) begin
      quad_nxt = (in_a != in_b) ? quad_nxt + 1'b1 : quad_nxt - 1'b1;
    end
    if (in_b != lb_r) begin
      quad_nxt = (in_a == in_b) ? quad_nxt + 1'b1 : quad_nxt - 1'b1;
    end
  end

  // heading code numerator from the raw heading: clamp, scale by 65535 / 32768
  logic signed [24:0] hn;
  logic [22:0]        hn_c;
  logic [39:0]        hn_w;
  always_comb begin
    hn = 25'(in_head) * 25'sd100 + 25'sd2572288;
    if (hn <= 0) hn_c = 23'd0;
    else if (hn >= 25'sd5144576) hn_c = 23'd5144576;
    else hn_c = hn[22:0];
    hn_w = {1'b0, hn_c, 16'd0} - 40'(hn_c);
  end

  // shared multiplier and operand select
  logic signed [32:0] op_a, op_b;
  logic signed [65:0] prod_r;
  logic [21:0]        mvx, mvy;

  assign mvx = qwo_pkg::vel_num(vx_r);
  assign mvy = qwo_pkg::vel_num(vy_r);

  always_comb begin
    op_a = '0;
    op_b = '0;
    case (state_r)
      ST_W1:   begin op_a = dq_r;                op_b = 33'(xgain_r); end
      ST_W2:   begin op_a = 33'(dt_r);           op_b = 33'(ygain_r); end
      ST_STP:  begin op_a = 33'(mag_r);
                     op_b = 33'(qwo_pkg::TWO_OVER_PI_Q32); end
      ST_LUT:  begin op_a = 33'(mh_r);  op_b = 33'(qwo_pkg::RECIP_157); end
      ST_A:    begin op_a = 33'(w1_r);  op_b = 33'(cos_r); end
      ST_B:    begin op_a = 33'(w2_r);  op_b = 33'(sin_r); end
      ST_C:    begin op_a = 33'(w1_r);  op_b = 33'(sin_r); end
      ST_D:    begin op_a = 33'(w2_r);  op_b = 33'(cos_r); end
      ST_E:    begin op_a = 33'(vx_r);  op_b = 33'(tper_r); end
      ST_F:    begin op_a = 33'(vy_r);  op_b = 33'(tper_r); end
      ST_G:    begin op_a = 33'(mvx);   op_b = 33'(qwo_pkg::RECIP_60); end
      ST_H:    begin op_a = 33'(mvy);   op_b = 33'(qwo_pkg::RECIP_60); end
      default: ;
    endcase
  end

  qwo_mul u_mul (
    .clk    (clk),
    .op_a   (op_a),
    .op_b   (op_b),
    .prod_r (prod_r)
  );

  // consume helpers
  logic [65:0]        step_w;
  logic [9:0]         sidx;
  logic signed [17:0] s_val, c_val;
  logic [24:0]        hrem, xrem, yrem;
  logic [15:0]        qh_fix, qx_fix, qy_fix;
  logic signed [65:0] prod_neg;
  logic signed [65:0] pos_step;

  always_comb begin
    step_w   = (prod_r + 66'sh800000000) >>> 36;
    sidx     = step_w[9:0];
    s_val    = qwo_pkg::sine_at(sidx);
    c_val    = qwo_pkg::sine_at(sidx + 10'd256);
    prod_neg = -prod_r;
    pos_step = qwo_pkg::rshift16(prod_r);
    hrem     = 25'(mh_r) - 25'(qh_r) * 25'd157;
    qh_fix   = (hrem >= 25'd157) ? qh_r + 16'd1 : qh_r;
    xrem     = 25'(mvx) - 25'(qx_r) * 25'd60;
    qx_fix   = (xrem >= 25'd60) ? qx_r + 16'd1 : qx_r;
    yrem     = 25'(mvy) - 25'(qy_r) * 25'd60;
    qy_fix   = (yrem >= 25'd60) ? qy_r + 16'd1 : qy_r;
  end

  // sequencer: walk the states once per tick, hold at the last one for a free slot
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (tick_acc) state_nxt = ST_W1;
      ST_J:    if (slot_free) state_nxt = ST_IDLE;
      default: state_nxt = state_r + 4'd1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      la_r        <= 1'b0;
      lb_r        <= 1'b0;
      quad_r      <= '0;
      cnt_tick_r  <= '0;
      tmr_tick_r  <= '0;
      posx_r      <= '0;
      posy_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (pin_acc) begin
        la_r   <= in_a;
        lb_r   <= in_b;
        quad_r <= quad_nxt;
      end
      if (tick_acc) begin
        cnt_tick_r <= quad_r;
        tmr_tick_r <= in_timer;
      end
      if (state_r == ST_F) posx_r <= posx_r + pos_step[31:0];
      if (state_r == ST_G) posy_r <= posy_r + pos_step[31:0];
      if (pin_acc || tick_done) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // tick datapath: latch operands at accept, then at most one consume per state
  always_ff @(posedge clk) begin
    if (tick_acc) begin
      dq_r    <= 33'($signed(quad_r - cnt_tick_r));
      dt_r    <= 17'($signed(in_timer - tmr_tick_r));
      mag_r   <= in_head[15] ? 17'd0 - 17'(in_head) : 17'(in_head);
      hneg_r  <= in_head[15];
      mh_r    <= hn_w[38:15];
    end
    case (state_r)
      ST_W2:  w1_r <= qwo_pkg::sat24(qwo_pkg::rshift8(prod_neg));
      ST_STP: w2_r <= qwo_pkg::sat24(qwo_pkg::rshift8(prod_r));
      ST_LUT: begin
        sin_r <= hneg_r ? -s_val : s_val;
        cos_r <= c_val;
      end
      ST_A:   qh_r  <= prod_r[47:32];
      ST_B: begin
        acc_r   <= prod_r;
        hcode_r <= qh_fix;
      end
      ST_C:   vx_r  <= qwo_pkg::sat24(qwo_pkg::rshift16(acc_r - prod_r));
      ST_D:   acc_r <= prod_r;
      ST_E:   vy_r  <= qwo_pkg::sat24(qwo_pkg::rshift16(acc_r + prod_r));
      ST_H:   qx_r  <= prod_r[47:32];
      ST_I: begin
        qy_r <= prod_r[47:32];
        qx_r <= qx_fix;
      end
      default: ;
    endcase
  end

  // output register: load on a pin sample or at the end of a tick
  always_ff @(posedge clk) begin
    if (pin_acc) begin
      o_count_r <= 32'($signed(quad_nxt));
      o_frame_r <= 1'b0;
      o_vx_r    <= '0;
      o_vy_r    <= '0;
      o_hd_r    <= '0;
      o_px_r    <= posx_r;
      o_py_r    <= posy_r;
    end else if (tick_done) begin
      o_count_r <= 32'($signed(quad_r));
      o_frame_r <= 1'b1;
      o_vx_r    <= qx_r;
      o_vy_r    <= qy_fix;
      o_hd_r    <= hcode_r;
      o_px_r    <= posx_r;
      o_py_r    <= posy_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = o_frame_r;
  assign out_tdata  = {o_py_r, o_px_r, o_hd_r, o_vy_r, o_vx_r, o_count_r};

`ifndef SYNTH
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> state_r == ST_IDLE)
    else $error("ready outside idle");
  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    tick_acc |=> state_r == ST_W1 && !in_tready)
    else $error("tick did not start sequencer");
  a_pin_result: assert property (@(posedge clk) disable iff (!rst_n)
    pin_acc |=> out_tvalid && !out_tuser)
    else $error("pin sample result missing");
  a_tick_result: assert property (@(posedge clk) disable iff (!rst_n)
    tick_done |=> out_tvalid && out_tuser && state_r == ST_IDLE)
    else $error("tick result missing");
`endif

endmodule

// File: bench/tb_quadrature_wheel_odometry_top.sv
`timescale 1ns / 1ps
// Self-checking bench for quadrature_wheel_odometry_top: decoder, tick velocity,
// heading codes and integrated position against an in-bench predictor.
// Depends on the RTL top level only (stream and plain write ports).
module tb_quadrature_wheel_odometry_top;

  localparam int  TBL_DEPTH = 256;
  localparam int  STALL_PCT = 9;
  localparam int  WATCHDOG  = 4000;
  localparam int  RAND_ITEMS = 820;

  // register indexes of the configuration port
  localparam logic [1:0] REG_X_GAIN = 2'd0;
  localparam logic [1:0] REG_Y_GAIN = 2'd1;
  localparam logic [1:0] REG_PERIOD = 2'd2;
  localparam logic [1:0] REG_NONE   = 2'd3;

  // tuser codes on the input side
  localparam logic FN_PIN  = 1'b0;
  localparam logic FN_TICK = 1'b1;

  typedef struct packed {
    logic        func;
    logic        pin_a;
    logic        pin_b;
    logic [15:0] timer;
    logic [15:0] heading;
  } sample_t;

  typedef struct packed {
    logic [31:0] count;
    logic        fresh;
    logic [15:0] vx;
    logic [15:0] vy;
    logic [15:0] hcode;
    logic [31:0] px;
    logic [31:0] py;
  } odo_t;

  logic         clk;
  logic         rst_n;
  logic         cfg_wr_en;
  logic [1:0]   cfg_index;
  logic [23:0]  cfg_data;
  logic         in_tvalid;
  logic         in_tready;
  logic [39:0]  in_tdata;
  logic         in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [143:0] out_tdata;
  logic         out_tuser;

  quadrature_wheel_odometry_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // pin_a, pin_b, timer_count[15:0], heading[15:0], pad
    .in_tuser   (in_tuser),   // func
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // decoder_count, vx, vy, heading_code, x_pos, y_pos
    .out_tuser  (out_tuser)   // frame_valid
  );

  // 8 ns clock
  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // predictor state
  logic [23:0] gain_x, gain_y;
  logic [15:0] period;
  logic        lvl_a, lvl_b;
  logic [31:0] quad_cnt, cnt_at_tick, pos_x, pos_y;
  logic [15:0] tmr_at_tick;
  logic [15:0] quarter_wave [TBL_DEPTH];

  sample_t pending_samples[$];
  odo_t    expected_odo[$];
  int      errors;
  int      idle_cycles;
  bit      calm;          // no random idling while set
  bit      in_fire, out_fire;

  // generator-side encoder and timer tracking
  logic gen_a, gen_b;
  logic [15:0] gen_timer;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic longint rnd_shift(input longint v, input int s);
    longint half;
    half = longint'(1) << (s - 1);
    if (v >= 0) return (v + half) >>> s;
    return -(((-v) + half) >>> s);
  endfunction

  function automatic longint clamp_q816(input longint v);
    if (v > 64'sd8388607) return 64'sd8388607;
    if (v < -64'sd8388608) return -64'sd8388608;
    return v;
  endfunction

  function automatic longint quarter_at(input int k);
    if (k >= TBL_DEPTH) return 65536;
    return longint'(quarter_wave[k]);
  endfunction

  // signed sine of a table step, four quarters per turn
  function automatic longint wave_at(input longint unsigned step);
    int idx, q, off;
    idx = int'(step % (4 * TBL_DEPTH));
    q   = idx / TBL_DEPTH;
    off = idx % TBL_DEPTH;
    case (q)
      0:       return quarter_at(off);
      1:       return quarter_at(TBL_DEPTH - off);
      2:       return -quarter_at(off);
      default: return -quarter_at(TBL_DEPTH - off);
    endcase
  endfunction

  function automatic logic [15:0] speed_code(input longint v);
    longint n, c;
    n = v + 1966080;
    if (n <= 0) return 16'd0;
    c = (n * 65535) / 3932160;
    return (c > 65535) ? 16'hFFFF : 16'(c);
  endfunction

  function automatic logic [15:0] angle_code(input longint h);
    longint n, c;
    n = 100 * h + 2572288;
    if (n <= 0) return 16'd0;
    c = (n * 65535) / 5144576;
    return (c > 65535) ? 16'hFFFF : 16'(c);
  endfunction

  task automatic fill_quarter_wave();
    longint unsigned x, x2, term, sum, val;
    for (int k = 0; k < TBL_DEPTH; k++) begin
      x    = (64'd1686629713 * longint'(k)) / TBL_DEPTH;
      x2   = (x * x) >> 30;
      term = x;
      sum  = x;
      for (int n = 1; n <= 8; n++) begin
        term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) sum = sum - term;
        else sum = sum + term;
      end
      val = (sum * 65536 + 64'd536870912) >> 30;
      quarter_wave[k] = (val > 65535) ? 16'hFFFF : val[15:0];
    end
  endtask

  // Advance the predictor by one accepted sample and queue its result.
  task automatic predict_odometry(input sample_t s);
    odo_t   r;
    longint dq, dt, h, w1, w2, sn, cs, vx, vy;
    longint unsigned mag, step;
    r = '0;
    if (s.func == FN_PIN) begin
      if (s.pin_a != lvl_a) begin
        lvl_a = s.pin_a;
        quad_cnt = (s.pin_a != s.pin_b) ? quad_cnt + 1 : quad_cnt - 1;
      end
      if (s.pin_b != lvl_b) begin
        lvl_b = s.pin_b;
        quad_cnt = (s.pin_a == s.pin_b) ? quad_cnt + 1 : quad_cnt - 1;
      end
    end else begin
      dq = longint'($signed(quad_cnt - cnt_at_tick));
      dt = longint'($signed(16'(s.timer - tmr_at_tick)));
      h  = longint'($signed(s.heading));
      cnt_at_tick = quad_cnt;
      tmr_at_tick = s.timer;
      w1 = clamp_q816(rnd_shift(-dq * longint'(gain_x), 8));
      w2 = clamp_q816(rnd_shift(dt * longint'(gain_y), 8));
      mag  = (h < 0) ? -h : h;
      step = (mag * TBL_DEPTH * 64'd2734261103 + (64'd1 << 43)) >> 44;
      sn = wave_at(step);
      cs = wave_at(step + TBL_DEPTH);
      if (h < 0) sn = -sn;
      vx = clamp_q816(rnd_shift(w1 * cs - w2 * sn, 16));
      vy = clamp_q816(rnd_shift(w1 * sn + w2 * cs, 16));
      pos_x = pos_x + 32'(rnd_shift(vx * longint'(period), 16));
      pos_y = pos_y + 32'(rnd_shift(vy * longint'(period), 16));
      r.fresh = 1'b1;
      r.vx    = speed_code(vx);
      r.vy    = speed_code(vy);
      r.hcode = angle_code(h);
    end
    r.count = quad_cnt;
    r.px    = pos_x;
    r.py    = pos_y;
    expected_odo.push_back(r);
  endtask

  // Sample handshakes at the rising edge; predict and check there.
  always @(posedge clk) begin
    odo_t e;
    in_fire  = rst_n && in_tvalid && in_tready;
    out_fire = rst_n && out_tvalid && out_tready;
    if (in_fire) begin
      predict_odometry(sample_t'({in_tuser, in_tdata[0], in_tdata[1],
                                  in_tdata[17:2], in_tdata[33:18]}));
    end
    if (out_fire) begin
      if (expected_odo.size() == 0) begin
        report("unexpected beat", out_tdata[31:0], 32'd0);
      end else begin
        e = expected_odo.pop_front();
        if (out_tdata[31:0] !== e.count) report("decoder_count", out_tdata[31:0], e.count);
        if (out_tuser !== e.fresh)
          report("frame_valid", 32'(out_tuser), 32'(e.fresh));
        if (out_tdata[47:32] !== e.vx)
          report("vx_code", 32'(out_tdata[47:32]), 32'(e.vx));
        if (out_tdata[63:48] !== e.vy)
          report("vy_code", 32'(out_tdata[63:48]), 32'(e.vy));
        if (out_tdata[79:64] !== e.hcode)
          report("heading_code", 32'(out_tdata[79:64]), 32'(e.hcode));
        if (out_tdata[111:80] !== e.px) report("x_position", out_tdata[111:80], e.px);
        if (out_tdata[143:112] !== e.py) report("y_position", out_tdata[143:112], e.py);
      end
    end
    // watchdog: any accepted beat resets the stall count
    if (in_fire || out_fire || !rst_n) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Driver: advance the input beat at the falling edge, idling at random.
  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || in_fire)) begin
      if (pending_samples.size() > 0 && (calm || $urandom_range(99) >= STALL_PCT)) begin
        sample_t s;
        s = pending_samples.pop_front();
        in_tvalid <= 1'b1;
        in_tuser  <= s.func;
        in_tdata  <= {6'd0, s.heading, s.timer, s.pin_b, s.pin_a};
      end else begin
        in_tvalid <= 1'b0;
        in_tdata  <= 40'({$urandom, $urandom});
      end
    end
    out_tready <= calm || ($urandom_range(99) >= STALL_PCT);
  end

  task automatic push_pin(input logic a, input logic b);
    pending_samples.push_back('{FN_PIN, a, b, 16'($urandom), 16'($urandom)});
  endtask

  task automatic push_tick(input logic [15:0] t, input logic [15:0] h);
    pending_samples.push_back('{FN_TICK, 1'($urandom), 1'($urandom), t, h});
  endtask

  // one quadrature step forward or back on the generator's encoder
  task automatic step_encoder(input bit fwd);
    logic na, nb;
    na = gen_a;
    nb = gen_b;
    if (fwd) begin
      if (gen_a == gen_b) nb = ~gen_b;
      else na = ~gen_a;
    end else begin
      if (gen_a == gen_b) na = ~gen_a;
      else nb = ~gen_b;
    end
    gen_a = na;
    gen_b = nb;
    push_pin(na, nb);
  endtask

  // Hold until every queued beat is accepted and every result is back.
  task automatic drain();
    while (pending_samples.size() > 0 || in_tvalid || expected_odo.size() > 0)
      @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == REG_X_GAIN) gain_x = val;
    else if (idx == REG_Y_GAIN) gain_y = val;
    else if (idx == REG_PERIOD) period = val[15:0];
  endtask

  task automatic random_run(input int n);
    int k, len;
    bit fwd;
    k = 0;
    while (k < n) begin
      case ($urandom_range(9))
        0: begin  // noise: arbitrary levels, both may flip together
          gen_a = 1'($urandom);
          gen_b = 1'($urandom);
          push_pin(gen_a, gen_b);
          k++;
        end
        1: begin  // long run for saturating speeds
          fwd = 1'($urandom);
          len = $urandom_range(300, 130);
          repeat (len) step_encoder(fwd);
          k += len;
        end
        default: begin
          fwd = 1'($urandom);
          len = $urandom_range(12);
          repeat (len) step_encoder(fwd);
          k += len;
        end
      endcase
      if ($urandom_range(3) == 0) gen_timer = 16'($urandom);
      else gen_timer = gen_timer + 16'($signed(9'($urandom)));
      push_tick(gen_timer, 16'($urandom));
      k++;
    end
  endtask

  initial begin
    rst_n      = 1'b0;
    cfg_wr_en  = 1'b0;
    cfg_index  = REG_X_GAIN;
    cfg_data   = '0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = FN_PIN;
    out_tready = 1'b0;
    errors     = 0;
    idle_cycles = 0;
    calm       = 1'b0;
    in_fire    = 1'b0;
    out_fire   = 1'b0;
    gain_x = 24'd219894;
    gain_y = 24'd219894;
    period = 16'd655;
    lvl_a = 1'b0;
    lvl_b = 1'b0;
    quad_cnt = '0;
    cnt_at_tick = '0;
    tmr_at_tick = '0;
    pos_x = '0;
    pos_y = '0;
    gen_a = 1'b0;
    gen_b = 1'b0;
    gen_timer = '0;
    fill_quarter_wave();
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: reset gains, forward and back steps, double flip, heading extremes
    repeat (4) step_encoder(1'b1);
    push_tick(16'd3, 16'h0000);
    repeat (3) step_encoder(1'b0);
    push_tick(16'hFFFE, 16'h7FFF);           // timer wraps backward
    push_pin(1'b1, 1'b1);                    // only pin_a changes here; both change on the next
    push_pin(1'b0, 1'b0);
    push_tick(16'h7FFF, 16'h8000);           // most negative heading
    push_tick(16'h8000, 16'h1922);           // quarter turn, sine at the table edge
    push_tick(16'h8000, 16'hE6DE);
    gen_a = 1'b0;
    gen_b = 1'b0;
    drain();

    // extremes of every register, with the unused index written too
    write_reg(REG_X_GAIN, 24'hFFFFFF);
    write_reg(REG_Y_GAIN, 24'hFFFFFF);
    write_reg(REG_PERIOD, 24'h00FFFF);
    write_reg(REG_NONE, 24'hABCDEF);
    calm = 1'b1;
    repeat (200) step_encoder(1'b1);
    push_tick(16'h7FFF, 16'h0C91);
    repeat (200) step_encoder(1'b0);
    push_tick(16'hFFFF, 16'hF36F);
    random_run(RAND_ITEMS / 5);
    drain();
    calm = 1'b0;

    write_reg(REG_X_GAIN, 24'd0);
    write_reg(REG_Y_GAIN, 24'd0);
    write_reg(REG_PERIOD, 24'd0);
    random_run(RAND_ITEMS / 10);
    drain();

    write_reg(REG_X_GAIN, 24'd219894);
    write_reg(REG_Y_GAIN, 24'd219894);
    write_reg(REG_PERIOD, 24'd655);
    random_run(RAND_ITEMS / 3);
    drain();

    write_reg(REG_X_GAIN, 24'($urandom));
    write_reg(REG_Y_GAIN, 24'($urandom));
    write_reg(REG_PERIOD, 24'($urandom));
    random_run(RAND_ITEMS / 3);
    drain();

    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: quadrature_wheel_odometry_top.f
rtl/qwo_pkg.sv
rtl/qwo_mul.sv
rtl/quadrature_wheel_odometry_top.sv
bench/tb_quadrature_wheel_odometry_top.sv
